>>> src/fpw_pkg.sv
// shared types and constants of the four-level page walker
`default_nettype none

package fpw_pkg;

    // store geometry
    localparam int STORE_ADDRESS_BITS = 12;
    localparam int MEM_ADDR_W         = 12;
    localparam int WIDX_W             = 49;
    localparam int STORE_WORDS        = 1 << STORE_ADDRESS_BITS;

    // field widths
    localparam int CMD_W    = 3;
    localparam int VA_W     = 48;
    localparam int DATA_W   = 64;
    localparam int BIT_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ROOT_W   = 52;
    localparam int IDX_W    = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_MEM_WR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MEM_RD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WALK_TEST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WALK_SET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WALK_CLR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WALK_FETCH = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // levels with a special meaning
    localparam logic [1:0] LVL_LARGE = 2'd2;
    localparam logic [1:0] LVL_LAST  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MEM_WR,
        OP_MEM_RD,
        OP_RD_ROOT,
        OP_RD_NEXT,
        OP_LEAF
    } t_dp_op;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_RAM,
        RES_LEAF
    } t_res_src;

    typedef struct packed {
        logic                load;
        logic                clr_we;
        t_dp_op              op;
        logic [1:0]          level;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        t_res_src            res_src;
        logic                res_large;
    } t_dp_cmd;

    typedef struct packed {
        logic             clr_last;
        logic [CMD_W-1:0] cmd;
        logic             direct_ok;
        logic             root_ok;
        logic             present;
        logic             ps_flag;
        logic             next_ok;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> src/fpw_if.sv
// request and result channels of the page walker
`default_nettype none

interface fpw_in_if;
    logic                                valid;
    logic                                ready;
    logic [fpw_pkg::CMD_W-1:0]           command;
    logic [fpw_pkg::VA_W-1:0]            virtual_address;
    logic [fpw_pkg::MEM_ADDR_W-1:0]      memory_word_address;
    logic [fpw_pkg::DATA_W-1:0]          write_data;
    logic [fpw_pkg::BIT_W-1:0]           bit_index;

    modport source (
        output valid, command, virtual_address, memory_word_address, write_data, bit_index,
        input  ready
    );
    modport sink (
        input  valid, command, virtual_address, memory_word_address, write_data, bit_index,
        output ready
    );
endinterface

interface fpw_out_if;
    logic                          valid;
    logic                          ready;
    logic [fpw_pkg::STATUS_W-1:0]  walk_status;
    logic [fpw_pkg::DATA_W-1:0]    read_data;
    logic                          bit_value;
    logic                          large_page;

    modport source (
        output valid, walk_status, read_data, bit_value, large_page,
        input  ready
    );
    modport sink (
        input  valid, walk_status, read_data, bit_value, large_page,
        output ready
    );
endinterface

`default_nettype wire

>>> src/four_level_page_walker.sv
// four-level page walker over a 4096-word store: one item at a time.
// a write, an unused command or an out-of-range address ends in the start state, a word
// read in the read state, a walk in the walk state (one store read per level, leaf update
// inline). each item is taken once the last is done and is held in the start state while
// an earlier result waits. after reset the store is zeroed one word a cycle, ready low; the
// root table base resets to zero; the user is to write it between items, not enforced.
`default_nettype none

module four_level_page_walker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [fpw_pkg::ROOT_W-1:0] i_cfg_wr_data,
    fpw_in_if.sink                          i_req,
    fpw_out_if.source                       o_rsp
);

    fpw_pkg::t_dp_cmd dp_cmd;
    fpw_pkg::t_dp_sts dp_sts;

    fpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    fpw_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_wr_data         (i_cfg_wr_data),
        .i_command             (i_req.command),
        .i_virtual_address     (i_req.virtual_address),
        .i_memory_word_address (i_req.memory_word_address),
        .i_write_data          (i_req.write_data),
        .i_bit_index           (i_req.bit_index),
        .i_cmd                 (dp_cmd),
        .o_sts                 (dp_sts),
        .o_walk_status         (o_rsp.walk_status),
        .o_read_data           (o_rsp.read_data),
        .o_bit_value           (o_rsp.bit_value),
        .o_large_page          (o_rsp.large_page)
    );

endmodule

`default_nettype wire

>>> src/fpw_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module fpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/fpw_dp.sv
// datapath of the page walker: item registers, store, slot arithmetic, result register
`default_nettype none

module fpw_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [fpw_pkg::ROOT_W-1:0]            i_cfg_wr_data,
    input  wire logic [fpw_pkg::CMD_W-1:0]             i_command,
    input  wire logic [fpw_pkg::VA_W-1:0]              i_virtual_address,
    input  wire logic [fpw_pkg::MEM_ADDR_W-1:0]        i_memory_word_address,
    input  wire logic [fpw_pkg::DATA_W-1:0]            i_write_data,
    input  wire logic [fpw_pkg::BIT_W-1:0]             i_bit_index,
    input  wire fpw_pkg::t_dp_cmd                      i_cmd,
    output fpw_pkg::t_dp_sts                           o_sts,
    output logic [fpw_pkg::STATUS_W-1:0]               o_walk_status,
    output logic [fpw_pkg::DATA_W-1:0]                 o_read_data,
    output logic                                       o_bit_value,
    output logic                                       o_large_page
);

    localparam int SAB = fpw_pkg::STORE_ADDRESS_BITS;

    logic [fpw_pkg::ROOT_W-1:0]     r_root;
    logic [fpw_pkg::CMD_W-1:0]      r_cmd;
    logic [fpw_pkg::VA_W-1:0]       r_va;
    logic [fpw_pkg::MEM_ADDR_W-1:0] r_waddr;
    logic [fpw_pkg::DATA_W-1:0]     r_wdata;
    logic [fpw_pkg::BIT_W-1:0]      r_bit;
    logic [SAB-1:0]                 r_slot;
    logic [SAB-1:0]                 r_clr_addr;

    logic [fpw_pkg::STATUS_W-1:0]   r_res_status;
    logic [fpw_pkg::DATA_W-1:0]     r_res_data;
    logic                           r_res_bit;
    logic                           r_res_large;

    logic [fpw_pkg::DATA_W-1:0]     rd_data;
    logic [fpw_pkg::WIDX_W-1:0]     root_w;
    logic [fpw_pkg::WIDX_W-1:0]     next_w;
    logic [fpw_pkg::WIDX_W-1:0]     direct_w;
    logic [fpw_pkg::DATA_W-1:0]     bit_mask;
    logic [fpw_pkg::DATA_W-1:0]     leaf_upd;
    logic                           leaf_bit;
    logic                           ram_we;
    logic [SAB-1:0]                 ram_waddr;
    logic [fpw_pkg::DATA_W-1:0]     ram_wdata;
    logic                           ram_re;
    logic [SAB-1:0]                 ram_raddr;

    function automatic logic [fpw_pkg::IDX_W-1:0] va_index(
        input logic [fpw_pkg::VA_W-1:0] va,
        input logic [1:0]               lvl
    );
        logic [fpw_pkg::IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

    // table base bits 12..51 shifted to words, entry index in the low nine bits
    assign root_w   = {r_root[51:12], va_index(r_va, 2'd0)};
    assign next_w   = {rd_data[51:12], va_index(r_va, i_cmd.level)};
    assign direct_w = {{(fpw_pkg::WIDX_W - fpw_pkg::MEM_ADDR_W){1'b0}}, r_waddr};

    assign bit_mask = {{(fpw_pkg::DATA_W - 1){1'b0}}, 1'b1} << r_bit;
    assign leaf_bit = rd_data[r_bit];

    always_comb begin
        case (r_cmd)
            fpw_pkg::CMD_WALK_SET: leaf_upd = rd_data | bit_mask;
            fpw_pkg::CMD_WALK_CLR: leaf_upd = rd_data & ~bit_mask;
            default:               leaf_upd = rd_data;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = leaf_upd;
        ram_re    = 1'b0;
        ram_raddr = direct_w[SAB-1:0];
        if (i_cmd.clr_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end
        case (i_cmd.op)
            fpw_pkg::OP_MEM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = direct_w[SAB-1:0];
                ram_wdata = r_wdata;
            end
            fpw_pkg::OP_MEM_RD: begin
                ram_re = 1'b1;
            end
            fpw_pkg::OP_RD_ROOT: begin
                ram_re    = 1'b1;
                ram_raddr = root_w[SAB-1:0];
            end
            fpw_pkg::OP_RD_NEXT: begin
                ram_re    = 1'b1;
                ram_raddr = next_w[SAB-1:0];
            end
            fpw_pkg::OP_LEAF: begin
                ram_we = (r_cmd == fpw_pkg::CMD_WALK_SET) || (r_cmd == fpw_pkg::CMD_WALK_CLR);
            end
            default: begin
            end
        endcase
    end

    fpw_ram #(
        .WIDTH (fpw_pkg::DATA_W),
        .DEPTH (fpw_pkg::STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_va    <= i_virtual_address;
            r_waddr <= i_memory_word_address;
            r_wdata <= i_write_data;
            r_bit   <= i_bit_index;
        end
        if (i_cmd.op == fpw_pkg::OP_RD_ROOT) begin
            r_slot <= root_w[SAB-1:0];
        end else if (i_cmd.op == fpw_pkg::OP_RD_NEXT) begin
            r_slot <= next_w[SAB-1:0];
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_large  <= i_cmd.res_large;
            case (i_cmd.res_src)
                fpw_pkg::RES_RAM: begin
                    r_res_data <= rd_data;
                    r_res_bit  <= 1'b0;
                end
                fpw_pkg::RES_LEAF: begin
                    r_res_data <= leaf_upd;
                    r_res_bit  <= (r_cmd == fpw_pkg::CMD_WALK_TEST) && leaf_bit;
                end
                default: begin
                    r_res_data <= '0;
                    r_res_bit  <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.clr_last  = &r_clr_addr;
    assign o_sts.cmd       = r_cmd;
    assign o_sts.direct_ok = (direct_w >> SAB) == '0;
    assign o_sts.root_ok   = (root_w >> SAB) == '0;
    assign o_sts.present   = rd_data[0];
    assign o_sts.ps_flag   = rd_data[7];
    assign o_sts.next_ok   = (next_w >> SAB) == '0;

    assign o_walk_status = r_res_status;
    assign o_read_data   = r_res_data;
    assign o_bit_value   = r_res_bit;
    assign o_large_page  = r_res_large;

endmodule

`default_nettype wire

>>> src/fpw_ctrl.sv
// controller of the page walker: clearing pass, command sequencing, result handshake
`default_nettype none

module fpw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire fpw_pkg::t_dp_sts i_sts,
    output fpw_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_MEM_RD,
        S_WALK
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_level;
    logic [1:0]       n_level;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;
    fpw_pkg::t_dp_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_level        = r_level;
        n_out_valid    = r_out_valid;
        cmd.load       = 1'b0;
        cmd.clr_we     = 1'b0;
        cmd.op         = fpw_pkg::OP_NONE;
        cmd.level      = r_level + 2'd1;
        cmd.res_load   = 1'b0;
        cmd.res_status = fpw_pkg::ST_OK;
        cmd.res_src    = fpw_pkg::RES_ZERO;
        cmd.res_large  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_START;
                end
            end
            S_START: begin
                // hold the item until the result register is sure to be free
                if (out_free) begin
                    n_level = 2'd0;
                    n_state = S_IDLE;
                    unique case (i_sts.cmd) inside
                        fpw_pkg::CMD_MEM_WR: begin
                            cmd.res_load = 1'b1;
                            if (i_sts.direct_ok) begin
                                cmd.op = fpw_pkg::OP_MEM_WR;
                            end else begin
                                cmd.res_status = fpw_pkg::ST_RANGE;
                            end
                        end
                        fpw_pkg::CMD_MEM_RD: begin
                            if (i_sts.direct_ok) begin
                                cmd.op  = fpw_pkg::OP_MEM_RD;
                                n_state = S_MEM_RD;
                            end else begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = fpw_pkg::ST_RANGE;
                            end
                        end
                        [fpw_pkg::CMD_WALK_TEST:fpw_pkg::CMD_WALK_FETCH]: begin
                            if (i_sts.root_ok) begin
                                cmd.op  = fpw_pkg::OP_RD_ROOT;
                                n_state = S_WALK;
                            end else begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = fpw_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_MEM_RD: begin
                cmd.res_load = 1'b1;
                cmd.res_src  = fpw_pkg::RES_RAM;
                n_state      = S_IDLE;
            end
            S_WALK: begin
                // entry of the current level is on the store read port
                if (!i_sts.present) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fpw_pkg::ST_NOMAP;
                    n_state        = S_IDLE;
                end else if (r_level == fpw_pkg::LVL_LAST
                             || (r_level == fpw_pkg::LVL_LARGE && i_sts.ps_flag)) begin
                    cmd.op        = fpw_pkg::OP_LEAF;
                    cmd.res_load  = 1'b1;
                    cmd.res_src   = fpw_pkg::RES_LEAF;
                    cmd.res_large = (r_level == fpw_pkg::LVL_LARGE) && i_sts.ps_flag;
                    n_state       = S_IDLE;
                end else if (i_sts.next_ok) begin
                    cmd.op  = fpw_pkg::OP_RD_NEXT;
                    n_level = r_level + 2'd1;
                end else begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fpw_pkg::ST_RANGE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_level     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

>>> sim/four_level_page_walker_tb.sv
// self-checking testbench of the four-level page walker with a shadow page-table predictor
`timescale 1ns / 100ps

module four_level_page_walker_tb;

    import fpw_pkg::*;

    // spare command codes, which the block answers with an empty ok result
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int PRESENT_BIT   = 0;
    localparam int PS_FLAG_BIT   = 7;
    localparam int TABLE_ENTRIES = 512;

    // the quiet limit outlasts the store clearing after reset and the long receiver hold
    localparam int QUIET_LIMIT   = 20000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 5;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [VA_W-1:0]       va;
        logic [MEM_ADDR_W-1:0] word_addr;
        logic [DATA_W-1:0]     wdata;
        logic [BIT_W-1:0]      bit_idx;
    } t_walk_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic                bit_value;
        logic                big_page;
    } t_walk_rsp;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [ROOT_W-1:0] cfg_wr_data;

    fpw_in_if  req_ch ();
    fpw_out_if rsp_ch ();

    four_level_page_walker i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    // shadow of the block's state
    logic [DATA_W-1:0] phys_mem [STORE_WORDS];
    logic [ROOT_W-1:0] root_base;

    t_walk_cmd cmd_backlog [$];
    t_walk_rsp walk_results_due [$];

    t_walk_cmd taken_cmd;
    t_walk_rsp seen, due;
    logic      req_taken;
    logic      idle_bursts;
    int        issued;
    int        mismatches;
    int        src_gap;
    int        sink_gap;
    int        hold_asked;
    int        hold_given;
    int        hold_left;
    int        quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // walk the shadow tables, apply the leaf update and work out the result
    function automatic t_walk_rsp walk_and_update(input t_walk_cmd c);
        t_walk_rsp             res;
        logic [ROOT_W-1:0]     tbl;
        logic [DATA_W-1:0]     entry;
        logic [WIDX_W-1:0]     widx;
        logic [MEM_ADDR_W-1:0] slot;
        int                    lvl;
        logic                  done;
        res   = '0;
        tbl   = root_base;
        entry = '0;
        slot  = '0;
        done  = 1'b0;
        case (c.command)
            CMD_MEM_WR, CMD_MEM_RD: begin
                if (c.word_addr >= STORE_WORDS) begin
                    res.status = ST_RANGE;
                end else if (c.command == CMD_MEM_WR) begin
                    phys_mem[c.word_addr] = c.wdata;
                end else begin
                    res.data = phys_mem[c.word_addr];
                end
            end
            CMD_WALK_TEST, CMD_WALK_SET, CMD_WALK_CLR, CMD_WALK_FETCH: begin
                for (lvl = 0; lvl < 4 && !done && res.status == ST_OK; lvl++) begin
                    widx = {tbl[ROOT_W-1:12], c.va[39 - 9 * lvl +: IDX_W]};
                    if (widx >= STORE_WORDS) begin
                        res.status = ST_RANGE;
                    end else begin
                        slot  = widx[MEM_ADDR_W-1:0];
                        entry = phys_mem[slot];
                        if (!entry[PRESENT_BIT]) begin
                            res.status = ST_NOMAP;
                        end else begin
                            if (lvl == LVL_LARGE && entry[PS_FLAG_BIT]) begin
                                res.big_page = 1'b1;
                                done         = 1'b1;
                            end else if (lvl == LVL_LAST) begin
                                done = 1'b1;
                            end
                            tbl = entry[ROOT_W-1:0];
                        end
                    end
                end
                if (res.status == ST_OK) begin
                    case (c.command)
                        CMD_WALK_SET:  entry[c.bit_idx] = 1'b1;
                        CMD_WALK_CLR:  entry[c.bit_idx] = 1'b0;
                        CMD_WALK_TEST: res.bit_value = entry[c.bit_idx];
                        default: ;
                    endcase
                    if (c.command == CMD_WALK_SET || c.command == CMD_WALK_CLR) begin
                        phys_mem[slot] = entry;
                    end
                    res.data = entry;
                end else begin
                    res.big_page = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [MEM_ADDR_W-1:0] entry_word(input int t, input int i);
        return MEM_ADDR_W'(t * TABLE_ENTRIES + i);
    endfunction

    function automatic logic [DATA_W-1:0] table_ptr(input int t, input logic [11:0] flags);
        logic [DATA_W-1:0] ptr;
        ptr              = '0;
        ptr[ROOT_W-1:12] = 40'(t);
        ptr[11:0]        = flags;
        return ptr;
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                              input logic [MEM_ADDR_W-1:0] waddr,
                              input logic [DATA_W-1:0] wdata, input logic [BIT_W-1:0] b);
        t_walk_cmd item;
        item = {cmd, va, waddr, wdata, b};
        cmd_backlog.push_back(item);
        issued++;
    endtask

    task automatic store_word(input logic [MEM_ADDR_W-1:0] waddr, input logic [DATA_W-1:0] d);
        logic [63:0] r;
        r = rand64();
        queue_item(CMD_MEM_WR, r[VA_W-1:0], waddr, d, r[BIT_W-1:0]);
    endtask

    task automatic fetch_word(input logic [MEM_ADDR_W-1:0] waddr);
        logic [63:0] r;
        r = rand64();
        queue_item(CMD_MEM_RD, r[VA_W-1:0], waddr, rand64(), r[BIT_W-1:0]);
    endtask

    task automatic walk_va(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                           input logic [BIT_W-1:0] b);
        queue_item(cmd, va, MEM_ADDR_W'($urandom_range(0, STORE_WORDS - 1)), rand64(), b);
    endtask

    // map a random address (four levels, three for a large page), then walk it a few times
    task automatic map_and_walk();
        logic [63:0]       r;
        logic [VA_W-1:0]   va;
        logic [DATA_W-1:0] entry;
        int                tbl_no [4];
        int                l;
        int                broken;
        logic              big;
        r         = rand64();
        va        = r[VA_W-1:0];
        tbl_no[0] = int'(root_base[14:12]);
        for (l = 1; l < 4; l++) begin
            tbl_no[l] = $urandom_range(0, 7);
        end
        big    = ($urandom_range(0, 3) == 0);
        broken = $urandom_range(0, 15);
        for (l = 0; l < 4; l++) begin
            if (!(l == 3 && big)) begin
                entry = rand64();
                if (l < 3) begin
                    entry[ROOT_W-1:12] = 40'(tbl_no[l + 1]);
                end
                entry[PRESENT_BIT] = 1'b1;
                if (l == 2) begin
                    entry[PS_FLAG_BIT] = big;
                end
                if (l == broken) begin
                    entry[PRESENT_BIT] = 1'b0;
                end else if (l == broken - 4) begin
                    // next table beyond the store
                    entry[$urandom_range(15, ROOT_W - 1)] = 1'b1;
                end
                store_word(entry_word(tbl_no[l], int'(va[39 - 9 * l +: IDX_W])), entry);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            walk_va(CMD_WALK_TEST + CMD_W'($urandom_range(0, 3)), va,
                    BIT_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic random_item();
        logic [63:0] a;
        a = rand64();
        queue_item(CMD_W'($urandom_range(0, 7)), a[VA_W-1:0],
                   MEM_ADDR_W'($urandom_range(0, STORE_WORDS - 1)), rand64(),
                   BIT_W'($urandom_range(0, 63)));
    endtask

    task automatic drain_and_settle();
        do begin
            @(negedge clk);
        end while (cmd_backlog.size() != 0 || walk_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_root(input logic [ROOT_W-1:0] base);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        root_base = base;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // request side: hold an item until taken, otherwise idle or offer the next one
    always @(negedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && !req_taken) begin
                // item still on offer
            end else if (src_gap > 0) begin
                src_gap = src_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 11);
                req_ch.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                req_ch.valid               <= 1'b1;
                req_ch.command             <= cmd_backlog[0].command;
                req_ch.virtual_address     <= cmd_backlog[0].va;
                req_ch.memory_word_address <= cmd_backlog[0].word_addr;
                req_ch.write_data          <= cmd_backlog[0].wdata;
                req_ch.bit_index           <= cmd_backlog[0].bit_idx;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result side ready, with bursts and the one long hold
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (hold_asked != hold_given) begin
                hold_given = hold_given + 1;
                hold_left  = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap = sink_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 11);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // results are checked before a request of the same edge is predicted
    always @(posedge clk) begin
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.walk_status, rsp_ch.read_data, rsp_ch.bit_value, rsp_ch.large_page};
            if (walk_results_due.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d data %h",
                         $time, seen.status, seen.data);
                mismatches++;
            end else begin
                due = walk_results_due.pop_front();
                if (seen.status !== due.status) begin
                    $display("%0t: walk_status expected %0d got %0d",
                             $time, due.status, seen.status);
                    mismatches++;
                end
                if (seen.data !== due.data) begin
                    $display("%0t: read_data expected %h got %h", $time, due.data, seen.data);
                    mismatches++;
                end
                if (seen.bit_value !== due.bit_value) begin
                    $display("%0t: bit_value expected %b got %b",
                             $time, due.bit_value, seen.bit_value);
                    mismatches++;
                end
                if (seen.big_page !== due.big_page) begin
                    $display("%0t: large_page expected %b got %b",
                             $time, due.big_page, seen.big_page);
                    mismatches++;
                end
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready) begin
            taken_cmd = {req_ch.command, req_ch.virtual_address, req_ch.memory_word_address,
                         req_ch.write_data, req_ch.bit_index};
            walk_results_due.push_back(walk_and_update(taken_cmd));
            void'(cmd_backlog.pop_front());
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("four_level_page_walker regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        int budget;
        rst_n                      = 1'b0;
        cfg_wr_en                  = 1'b0;
        cfg_wr_data                = '0;
        req_ch.valid               = 1'b0;
        req_ch.command             = '0;
        req_ch.virtual_address     = '0;
        req_ch.memory_word_address = '0;
        req_ch.write_data          = '0;
        req_ch.bit_index           = '0;
        rsp_ch.ready               = 1'b0;
        req_taken                  = 1'b0;
        idle_bursts                = 1'b1;
        issued                     = 0;
        mismatches                 = 0;
        src_gap                    = 0;
        sink_gap                   = 0;
        hold_asked                 = 0;
        hold_given                 = 0;
        hold_left                  = 0;
        quiet_cycles               = 0;
        root_base                  = '0;
        phys_mem                   = '{default: '0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // root table at zero from reset
        fetch_word(entry_word(0, 0));
        fetch_word(entry_word(7, TABLE_ENTRIES - 1));
        walk_va(CMD_WALK_FETCH, '0, '0);
        store_word(entry_word(7, TABLE_ENTRIES - 1), '1);
        fetch_word(entry_word(7, TABLE_ENTRIES - 1));
        // all-ones address: every level at entry 511, page size bit set where it is ignored
        store_word(entry_word(0, TABLE_ENTRIES - 1), table_ptr(1, 12'h081) | {12'hFFF, 52'h0});
        store_word(entry_word(1, TABLE_ENTRIES - 1), table_ptr(2, 12'h083));
        store_word(entry_word(2, TABLE_ENTRIES - 1), table_ptr(3, 12'h003));
        store_word(entry_word(3, TABLE_ENTRIES - 1), 64'h8765_4321_0FED_C081);
        walk_va(CMD_WALK_FETCH, '1, '0);
        walk_va(CMD_WALK_TEST, '1, 6'd63);
        walk_va(CMD_WALK_SET, '1, 6'd1);
        walk_va(CMD_WALK_CLR, '1, 6'd0);
        walk_va(CMD_WALK_TEST, '1, 6'd0);
        // large page at the third level for the bottom of the address space
        store_word(entry_word(0, 0), table_ptr(4, 12'h001));
        store_word(entry_word(4, 0), table_ptr(5, 12'h001));
        store_word(entry_word(5, 0), table_ptr(6, 12'h0E3));
        walk_va(CMD_WALK_TEST, 48'h0000_001F_FFFF, 6'd7);
        walk_va(CMD_WALK_SET, 48'h0000_0012_3456, 6'd63);
        fetch_word(entry_word(5, 0));
        // next table beyond the store
        store_word(entry_word(0, 1), table_ptr(8, 12'h001));
        walk_va(CMD_WALK_FETCH, 48'h0080_0000_0000, '0);
        store_word(entry_word(0, 2), 64'h0008_0000_0000_1001);
        walk_va(CMD_WALK_CLR, 48'h0100_0000_0000, 6'd3);
        walk_va(CMD_SPARE_A, '1, '1);
        walk_va(CMD_SPARE_B, '1, '1);
        drain_and_settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin write_root(52'h0_0000_0000_2FFF); budget = 520; end
                1: begin write_root(52'h0_0000_0000_8000); budget = 130; end
                2: begin write_root(52'hF_FFFF_FFFF_F000); budget = 130; end
                3: begin write_root(52'h0_0000_0000_7000); budget = 520; end
                default: begin write_root('0); budget = 520; end
            endcase
            @(posedge clk);
            if (ph == 0) begin
                hold_asked = hold_asked + 1;
            end
            if (ph == PHASES - 1) begin
                idle_bursts = 1'b0;
            end
            issued = 0;
            while (issued < budget) begin
                if ($urandom_range(0, 3) != 0) begin
                    map_and_walk();
                end else begin
                    random_item();
                end
            end
            drain_and_settle();
        end

        if (mismatches == 0) begin
            $display("four_level_page_walker regression: pass");
        end else begin
            $display("four_level_page_walker regression: fail");
        end
        $finish;
    end

endmodule
